// ===== rtl/mas_pkg.sv =====
package mas_pkg;

  // build-time defaults
  localparam int MATRIX_DIM_DEF = 4;

  // fixed field widths
  localparam int VAL_W  = 32;
  localparam int IDX_W  = 4;
  localparam int MODE_W = 2;
  localparam int PROD_W = 2 * VAL_W;
  localparam int FRAC_W = 16;

  // op_mode codes and the bits that decode them
  localparam logic [MODE_W-1:0] OP_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] OP_SUB   = 2'd1;
  localparam logic [MODE_W-1:0] OP_MUL   = 2'd2;
  // spare code, decoded as multiply
  localparam logic [MODE_W-1:0] OP_SPARE = 2'd3;
  localparam int OP_SUB_BIT = 0;
  localparam int OP_MUL_BIT = 1;

  // saturation limits
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic [IDX_W-1:0]        element_index;
    logic signed [VAL_W-1:0] left_value;
    logic signed [VAL_W-1:0] right_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        result_index;
    logic signed [VAL_W-1:0] result_value;
    logic                    saturated;
    logic                    last_of_run;
  } out_item_t;

  // one step for the shared arithmetic unit
  typedef struct packed {
    logic step;
    logic first;
    logic last;
    logic mul;
    logic sub;
  } mas_ctl_t;

  // finished element from the arithmetic unit
  typedef struct packed {
    logic                    done;
    logic signed [VAL_W-1:0] value;
    logic                    sat;
  } mas_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FLUSH,
    ST_EMIT
  } mas_state_t;

endpackage

// ===== rtl/mas_alu.sv =====
module mas_alu
  import mas_pkg::*;
#(
  parameter int MATRIX_DIM = MATRIX_DIM_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mas_ctl_t                ctl,
  input  logic signed [VAL_W-1:0] lhs,
  input  logic signed [VAL_W-1:0] rhs,
  output mas_res_t                res
);

  localparam int ACC_W = PROD_W + $clog2(MATRIX_DIM);

  logic signed [PROD_W-1:0] prod;
  logic signed [VAL_W:0]    sum_ext;
  logic signed [ACC_W-1:0]  term_nxt;
  logic signed [ACC_W-1:0]  term_r;
  mas_ctl_t                 ctl_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     acc_mul_r;
  logic                     done_r;
  logic signed [ACC_W-1:0]  acc_shr;
  logic signed [ACC_W-1:0]  sel;
  logic [ACC_W-VAL_W:0]     upper;
  logic                     in_range;

  // term stage: one product, or the exact sum or difference
  always_comb begin
    prod = lhs * rhs;
    if (ctl.sub) begin
      sum_ext = $signed({lhs[VAL_W-1], lhs}) - $signed({rhs[VAL_W-1], rhs});
    end else begin
      sum_ext = $signed({lhs[VAL_W-1], lhs}) + $signed({rhs[VAL_W-1], rhs});
    end
    if (ctl.mul) begin
      term_nxt = ACC_W'(prod);
    end else begin
      term_nxt = ACC_W'(sum_ext);
    end
  end

  always_ff @(posedge clk) begin
    term_r <= term_nxt;
  end

  // stage flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= '0;
      done_r <= 1'b0;
    end else begin
      ctl_r  <= ctl;
      done_r <= ctl_r.step && ctl_r.last;
    end
  end

  // accumulate over the shared dimension at full precision
  always_ff @(posedge clk) begin
    if (ctl_r.step) begin
      if (ctl_r.first) begin
        acc_r <= term_r;
      end else begin
        acc_r <= acc_r + term_r;
      end
      acc_mul_r <= ctl_r.mul;
    end
  end

  // drop the fraction of a product sum (floor) and clamp to 32 bits
  always_comb begin
    acc_shr  = acc_r >>> FRAC_W;
    sel      = acc_mul_r ? acc_shr : acc_r;
    upper    = sel[ACC_W-1:VAL_W-1];
    in_range = (&upper) || !(|upper);
    res.done = done_r;
    res.sat  = !in_range;
    if (in_range) begin
      res.value = sel[VAL_W-1:0];
    end else if (sel[ACC_W-1]) begin
      res.value = VAL_MIN;
    end else begin
      res.value = VAL_MAX;
    end
  end

endmodule

// ===== rtl/matrix_add_sub_multiply_4x4.sv =====
// Matrix add / subtract / multiply for two square MATRIX_DIM x MATRIX_DIM
// matrices of signed Q16.16 values. Each input item writes one left/right
// element pair at its row-major position; positions beyond the matrix are
// dropped. in_ready is high while idle, so loads go in at one item per cycle.
// The item carrying the final position starts a burst of MATRIX_DIM^2 results
// in row-major order (add, subtract right from left, or left times right as
// cfg_wdata last set op_mode; reset selects multiply), each clamped to the
// 32-bit range with the saturated flag set when clamped; last_of_run marks the
// final result. During the burst in_ready is low. Every result goes through a
// single multiply-accumulate unit fed from one read port per element store:
// a product element takes one accumulate step per cycle over the shared
// dimension, then store read, multiply, accumulate and output hand-off; a
// sum or difference element takes a single step through the same stages. A
// finished result then waits until the output register is free.
// A result may wait in the output register while the next one is computed.
// The element stores are not cleared by reset; load every position before
// the first run.
module matrix_add_sub_multiply_4x4
  import mas_pkg::*;
#(
  parameter int MATRIX_DIM = MATRIX_DIM_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [MODE_W-1:0] cfg_wdata
);

  localparam int ELEM_COUNT = MATRIX_DIM * MATRIX_DIM;
  localparam int AW = $clog2(ELEM_COUNT);
  localparam int KW = $clog2(MATRIX_DIM);
  localparam logic [KW-1:0] K_LAST = KW'(MATRIX_DIM - 1);
  localparam logic [AW-1:0] N_LAST = AW'(ELEM_COUNT - 1);

  mas_state_t              state_r, state_nxt;
  logic [MODE_W-1:0]       op_mode_r;
  logic [AW-1:0]           n_r;
  logic [KW-1:0]           row_r, col_r, k_r;
  logic                    in_fire, idx_hit, idx_final, wr_en;
  logic [AW-1:0]           wr_addr, left_addr, right_addr;
  logic                    mul_mode, step_last, out_free, out_load;
  mas_ctl_t                ctl_nxt, ctl_r;
  mas_res_t                res;
  logic signed [VAL_W-1:0] left_mem  [ELEM_COUNT];
  logic signed [VAL_W-1:0] right_mem [ELEM_COUNT];
  logic signed [VAL_W-1:0] left_rd_r, right_rd_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  // input decode
  assign in_fire   = in_valid && in_ready;
  assign idx_hit   = int'(in_data.element_index) < ELEM_COUNT;
  assign idx_final = int'(in_data.element_index) == ELEM_COUNT - 1;
  assign wr_en     = in_fire && idx_hit;
  assign wr_addr   = AW'(in_data.element_index);
  assign mul_mode  = op_mode_r[OP_MUL_BIT];
  assign step_last = !mul_mode || (k_r == K_LAST);
  assign out_free  = !out_valid_r || out_ready;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r <= OP_MUL;
    end else if (cfg_we) begin
      op_mode_r <= cfg_wdata;
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (wr_en && idx_final) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (step_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (res.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = (n_r == N_LAST) ? ST_IDLE : ST_MAC;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer outputs
  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    out_load      = (state_r == ST_EMIT) && out_free;
    ctl_nxt.step  = (state_r == ST_MAC);
    ctl_nxt.first = (k_r == '0);
    ctl_nxt.last  = step_last;
    ctl_nxt.mul   = mul_mode;
    ctl_nxt.sub   = op_mode_r[OP_SUB_BIT];
    if (mul_mode) begin
      left_addr  = AW'(int'(row_r) * MATRIX_DIM + int'(k_r));
      right_addr = AW'(int'(k_r) * MATRIX_DIM + int'(col_r));
    end else begin
      left_addr  = n_r;
      right_addr = n_r;
    end
  end

  // element and step counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r   <= '0;
      row_r <= '0;
      col_r <= '0;
      k_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          n_r   <= '0;
          row_r <= '0;
          col_r <= '0;
          k_r   <= '0;
        end
        ST_MAC: begin
          k_r <= step_last ? '0 : k_r + 1'b1;
        end
        ST_EMIT: begin
          if (out_free) begin
            n_r <= n_r + 1'b1;
            if (col_r == K_LAST) begin
              col_r <= '0;
              row_r <= row_r + 1'b1;
            end else begin
              col_r <= col_r + 1'b1;
            end
          end
        end
        default: begin
          k_r <= k_r;
        end
      endcase
    end
  end

  // element stores, one write and one registered read each
  always_ff @(posedge clk) begin
    if (wr_en) begin
      left_mem[wr_addr]  <= in_data.left_value;
      right_mem[wr_addr] <= in_data.right_value;
    end
    left_rd_r  <= left_mem[left_addr];
    right_rd_r <= right_mem[right_addr];
  end

  // step flags follow the read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  mas_alu #(
    .MATRIX_DIM (MATRIX_DIM)
  ) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_r),
    .lhs   (left_rd_r),
    .rhs   (right_rd_r),
    .res   (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.result_index <= IDX_W'(n_r);
      out_data_r.result_value <= res.value;
      out_data_r.saturated    <= res.sat;
      out_data_r.last_of_run  <= (n_r == N_LAST);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/mas_checker.sv =====
module mas_checker
  import mas_pkg::*;
#(
  parameter int MATRIX_DIM = MATRIX_DIM_DEF
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  localparam int ELEM_COUNT = MATRIX_DIM * MATRIX_DIM;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ELEM_COUNT - 1);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // loads are closed while a burst is still running
  a_busy_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_of_run |-> !in_ready)
    else $error("input open during result burst");

  // a clamped item carries one of the two limits
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      (out_data.result_value == VAL_MAX) || (out_data.result_value == VAL_MIN))
    else $error("saturated item not at a limit");

  // end of burst marker sits on the final position only
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_of_run == (out_data.result_index == IDX_LAST)))
    else $error("last_of_run on wrong position");

  // the item after a non-final one is the next position
  a_next_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_of_run ##1 out_valid |->
      out_data.result_index == IDX_W'($past(out_data.result_index) + 1'b1))
    else $error("result positions out of order");

endmodule

bind matrix_add_sub_multiply_4x4 mas_checker #(
  .MATRIX_DIM (MATRIX_DIM)
) u_mas_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
